// ===== sv/sgrg_pkg.sv =====
// Shared types, constants and glyph table of the scaled glyph row generator.
`timescale 1ns / 1ps
package sgrg_pkg;

	localparam int MAX_SCALE_DEF  = 8;
	localparam int COORD_BITS_DEF = 12;

	localparam int CODE_W    = 8;
	localparam int ORIGIN_W  = 12;
	localparam int ADDR_W    = 24;
	localparam int MASK_W    = 24;
	localparam int COLOR_W   = 24;
	localparam int FW_W      = 13;
	localparam int SCALE_CFG_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam int GLYPH_ROWS    = 5;
	localparam int GLYPH_COLS    = 3;
	localparam int GLYPH_ADVANCE = 4;
	localparam int GLYPH_BITS    = GLYPH_ROWS * GLYPH_COLS;
	localparam int GLYPH_COUNT   = 95;

	localparam logic [CODE_W-1:0] FIRST_PRINT = 8'd33;
	localparam logic [CODE_W-1:0] LAST_PRINT  = 8'd126;
	localparam logic [CODE_W-1:0] TABLE_BASE  = 8'd32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd2;

	localparam logic [SCALE_CFG_W-1:0] SCALE_RESET = 4'd4;
	localparam logic [COLOR_W-1:0]     COLOR_RESET = 24'hFFFFFF;
	localparam logic [FW_W-1:0]        FW_RESET    = 13'd1024;

	localparam logic [15:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
		16'h0000, 16'h2092, 16'h002d, 16'h5f7d, 16'h279e, 16'h52a5, 16'h7ad6, 16'h0012,
		16'h4494, 16'h1491, 16'h017a, 16'h05d0, 16'h1400, 16'h01c0, 16'h0400, 16'h12a4,
		16'h2b6a, 16'h749a, 16'h752a, 16'h38a3, 16'h4f4a, 16'h38cf, 16'h3bce, 16'h12a7,
		16'h3aae, 16'h49ae, 16'h0410, 16'h1410, 16'h4454, 16'h0e38, 16'h1511, 16'h10e3,
		16'h73ee, 16'h5f7a, 16'h3beb, 16'h624e, 16'h3b6b, 16'h73cf, 16'h13cf, 16'h6b4e,
		16'h5bed, 16'h7497, 16'h2b27, 16'h5add, 16'h7249, 16'h5b7d, 16'h5b6b, 16'h3b6e,
		16'h12eb, 16'h4f6b, 16'h5aeb, 16'h388e, 16'h2497, 16'h6b6d, 16'h256d, 16'h5f6d,
		16'h5aad, 16'h24ad, 16'h72a7, 16'h6496, 16'h4889, 16'h3493, 16'h002a, 16'hf000,
		16'h0011, 16'h6b98, 16'h3b79, 16'h7270, 16'h7b74, 16'h6750, 16'h95d6, 16'hb9ee,
		16'h5b59, 16'h6410, 16'hb482, 16'h56e8, 16'h6492, 16'h5be8, 16'h5b58, 16'h3b70,
		16'h976a, 16'hcd6a, 16'h1370, 16'h38f0, 16'h64ba, 16'h3b68, 16'h2568, 16'h5f68,
		16'h54a8, 16'hb9ad, 16'h73b8, 16'h64d6, 16'h2492, 16'h3593, 16'h03e0
	};

	function automatic logic is_printable(logic [CODE_W-1:0] code);
		return (code >= FIRST_PRINT) && (code <= LAST_PRINT);
	endfunction

	// Font dots of a printable code, bit 15 dropped; blank for anything else
	function automatic logic [GLYPH_BITS-1:0] glyph_bits(logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] idx;
		logic [15:0]       word;
		idx  = code - TABLE_BASE;
		word = 16'h0000;
		if (is_printable(code)) begin
			word = GLYPH_ROM[idx[6:0]];
		end
		return word[GLYPH_BITS-1:0];
	endfunction

	typedef struct packed {
		logic accept;   // latch item, load pen on start_string
		logic mul;      // base address = pen_y * frame_width
		logic emit;     // load one row into the output register
		logic adv;      // advance the pen
	} sgrg_cmd_t;

	typedef struct packed {
		logic printable;  // code at the input is a drawn glyph
		logic out_free;   // output register can take a row
		logic last;       // current row is the glyph's final one
	} sgrg_status_t;

endpackage

// ===== sv/sgrg_if.sv =====
// Handshake channels: character items in, glyph rows out.
`timescale 1ns / 1ps
interface sgrg_in_if;
	logic                              valid;
	logic                              ready;
	logic [sgrg_pkg::CODE_W-1:0]       char_code;
	logic                              start_string;
	logic [sgrg_pkg::ORIGIN_W-1:0]     origin_x;
	logic [sgrg_pkg::ORIGIN_W-1:0]     origin_y;

	modport source (output valid, output char_code, output start_string,
		output origin_x, output origin_y, input ready);
	modport sink (input valid, input char_code, input start_string,
		input origin_x, input origin_y, output ready);
endinterface

interface sgrg_row_if;
	logic                              valid;
	logic                              ready;
	logic [sgrg_pkg::ADDR_W-1:0]       row_address;
	logic [sgrg_pkg::MASK_W-1:0]       row_mask;
	logic [sgrg_pkg::COLOR_W-1:0]      row_color;
	logic                              last_row;

	modport source (output valid, output row_address, output row_mask,
		output row_color, output last_row, input ready);
	modport sink (input valid, input row_address, input row_mask,
		input row_color, input last_row, output ready);
endinterface

// ===== sv/scaled_glyph_row_generator_top.sv =====
// Top level of the scaled glyph row generator.
`timescale 1ns / 1ps
// Draws one character of a 3x5 dot font per input item as a run of framebuffer rows.
// A printable code (33..126) produces 5*scale rows, one per cycle while the output
// is taken; each row carries its frame address, a pixel mask with every dot widened
// to scale pixels, the ink color, and last_row on the final one. An item is handled
// in order: accept and look up the font, the pen_y * frame_width multiply that
// seeds the address, the rows through the output register, and the pen advance by
// 4*scale (saturating). Other codes only move the pen. Output stalls stretch the
// row phase. A finished row waits in the output register while the next item is
// taken. Configuration is written through cfg_write_en/cfg_index/cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
module scaled_glyph_row_generator_top #(
	parameter int MAX_SCALE  = sgrg_pkg::MAX_SCALE_DEF,
	parameter int COORD_BITS = sgrg_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [sgrg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgrg_pkg::CFG_DATA_W-1:0]    cfg_data,
	sgrg_in_if.sink                            in_ch,
	sgrg_row_if.source                         out_ch
);

	sgrg_pkg::sgrg_cmd_t    cmd;
	sgrg_pkg::sgrg_status_t status;

	sgrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	sgrg_datapath #(
		.MAX_SCALE  (MAX_SCALE),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.char_code    (in_ch.char_code),
		.start_string (in_ch.start_string),
		.origin_x     (in_ch.origin_x),
		.origin_y     (in_ch.origin_y),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.row_address  (out_ch.row_address),
		.row_mask     (out_ch.row_mask),
		.row_color    (out_ch.row_color),
		.last_row     (out_ch.last_row)
	);

`ifndef SYNTHESIS
	// A row never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_ch.valid || out_ch.ready))
		else $error("row loaded over a stalled row");

	// One item in flight: taking an item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item accepted while one is in work");

	// After the final row the glyph is done: no further row, pen update next
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.last) |=> (cmd.adv && !cmd.emit && !in_ch.ready))
		else $error("rows continue past the last row");
`endif

endmodule

// ===== sv/sgrg_ctrl.sv =====
// Controller: sequences accept, base multiply, row emission and pen advance.
`timescale 1ns / 1ps
module sgrg_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sgrg_pkg::sgrg_status_t status,
	output sgrg_pkg::sgrg_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_ROW  = 4'b0100,
		S_ADV  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.mul    = (state_q == S_MUL);
		cmd.emit   = (state_q == S_ROW) && status.out_free;
		cmd.adv    = (state_q == S_ADV);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = status.printable ? S_MUL : S_ADV;
				end
			end
			S_MUL: state_d = S_ROW;
			S_ROW: begin
				if (status.out_free && status.last) begin
					state_d = S_ADV;
				end
			end
			S_ADV: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/sgrg_datapath.sv =====
// Datapath: config registers, pen, font lookup, row address and mask, output register.
`timescale 1ns / 1ps
module sgrg_datapath #(
	parameter int MAX_SCALE  = sgrg_pkg::MAX_SCALE_DEF,
	parameter int COORD_BITS = sgrg_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [sgrg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sgrg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [sgrg_pkg::CODE_W-1:0]         char_code,
	input  logic                                start_string,
	input  logic [sgrg_pkg::ORIGIN_W-1:0]       origin_x,
	input  logic [sgrg_pkg::ORIGIN_W-1:0]       origin_y,
	input  sgrg_pkg::sgrg_cmd_t                 cmd,
	output sgrg_pkg::sgrg_status_t              status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [sgrg_pkg::ADDR_W-1:0]         row_address,
	output logic [sgrg_pkg::MASK_W-1:0]         row_mask,
	output logic [sgrg_pkg::COLOR_W-1:0]        row_color,
	output logic                                last_row
);

	localparam int SCALE_W = $clog2(MAX_SCALE + 1);
	localparam int PROD_W  = COORD_BITS + sgrg_pkg::FW_W;
	localparam int ADDR_W  = sgrg_pkg::ADDR_W;
	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

	// Configuration
	logic [sgrg_pkg::SCALE_CFG_W-1:0] scale_cfg_q;
	logic [sgrg_pkg::COLOR_W-1:0]     color_q;
	logic [sgrg_pkg::FW_W-1:0]        fw_q;

	// Per-item state
	logic [COORD_BITS-1:0]            pen_x_q, pen_y_q;
	logic [SCALE_W-1:0]               sc_q;
	logic [sgrg_pkg::GLYPH_BITS-1:0]  bits_q;
	logic [ADDR_W-1:0]                addr_q;
	logic [2:0]                       dy_q;
	logic [SCALE_W-1:0]               sub_q;

	// Output register
	logic                             out_valid_q;
	logic [ADDR_W-1:0]                out_addr_q;
	logic [sgrg_pkg::MASK_W-1:0]      out_mask_q;
	logic [sgrg_pkg::COLOR_W-1:0]     out_color_q;
	logic                             out_last_q;

	logic [SCALE_W-1:0]               eff_scale;
	logic [PROD_W-1:0]                prod;
	logic [2:0]                       dots;
	logic [4:0]                       b1, b2, b3;
	logic [sgrg_pkg::MASK_W-1:0]      mask_row;
	logic                             sub_end;
	logic [COORD_BITS:0]              next_x;

	always_comb begin
		if (scale_cfg_q == '0) begin
			eff_scale = SCALE_W'(1);
		end else if (scale_cfg_q > sgrg_pkg::SCALE_CFG_W'(MAX_SCALE)) begin
			eff_scale = SCALE_W'(MAX_SCALE);
		end else begin
			eff_scale = SCALE_W'(scale_cfg_q);
		end
	end

	assign prod = PROD_W'(pen_y_q) * PROD_W'(fw_q);

	assign dots = bits_q[4'(dy_q) * 4'd3 +: 3];

	// Column dx of the glyph covers mask bits [dx*sc, (dx+1)*sc)
	assign b1 = 5'(sc_q);
	assign b2 = 5'(sc_q) + 5'(sc_q);
	assign b3 = b2 + 5'(sc_q);

	always_comb begin
		for (int k = 0; k < sgrg_pkg::MASK_W; k++) begin
			mask_row[k] = (dots[0] && (5'(k) < b1))
				|| (dots[1] && (5'(k) >= b1) && (5'(k) < b2))
				|| (dots[2] && (5'(k) >= b2) && (5'(k) < b3));
		end
	end

	assign sub_end = (sub_q == sc_q - SCALE_W'(1));

	assign next_x = {1'b0, pen_x_q}
		+ (COORD_BITS + 1)'({sc_q, 2'b00});

	assign status.printable = sgrg_pkg::is_printable(char_code);
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.last      = (dy_q == 3'(sgrg_pkg::GLYPH_ROWS - 1)) && sub_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_cfg_q <= sgrg_pkg::SCALE_RESET;
			color_q     <= sgrg_pkg::COLOR_RESET;
			fw_q        <= sgrg_pkg::FW_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				sgrg_pkg::REG_PIXEL_SCALE: scale_cfg_q <= cfg_data[sgrg_pkg::SCALE_CFG_W-1:0];
				sgrg_pkg::REG_INK_COLOR:   color_q     <= cfg_data[sgrg_pkg::COLOR_W-1:0];
				sgrg_pkg::REG_FRAME_WIDTH: fw_q        <= cfg_data[sgrg_pkg::FW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			dy_q    <= '0;
			sub_q   <= '0;
		end else begin
			if (cmd.accept) begin
				if (start_string) begin
					pen_x_q <= origin_x[COORD_BITS-1:0];
					pen_y_q <= origin_y[COORD_BITS-1:0];
				end
				dy_q  <= '0;
				sub_q <= '0;
			end
			if (cmd.emit) begin
				if (sub_end) begin
					sub_q <= '0;
					dy_q  <= dy_q + 3'd1;
				end else begin
					sub_q <= sub_q + SCALE_W'(1);
				end
			end
			if (cmd.adv) begin
				pen_x_q <= next_x[COORD_BITS] ? COORD_MAX : next_x[COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sc_q   <= eff_scale;
			bits_q <= sgrg_pkg::glyph_bits(char_code);
		end
		if (cmd.mul) begin
			addr_q <= ADDR_W'(prod);
		end else if (cmd.emit) begin
			addr_q <= addr_q + ADDR_W'(fw_q);
		end
		if (cmd.emit) begin
			out_addr_q  <= addr_q + ADDR_W'(pen_x_q);
			out_mask_q  <= mask_row;
			out_color_q <= color_q;
			out_last_q  <= status.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign row_address = out_addr_q;
	assign row_mask    = out_mask_q;
	assign row_color   = out_color_q;
	assign last_row    = out_last_q;

endmodule

// ===== tb/scaled_glyph_row_generator_top_tb.sv =====
// Self-checking testbench of the scaled glyph row generator: directed table, then random strings.
`timescale 1ns / 1ps
module scaled_glyph_row_generator_top_tb;
	import sgrg_pkg::*;

	localparam int COORD_MAX   = (1 << COORD_BITS_DEF) - 1;
	localparam int BURST_ITEMS = 20;

	typedef struct {
		logic [CODE_W-1:0]   code;
		logic                start;
		logic [ORIGIN_W-1:0] ox;
		logic [ORIGIN_W-1:0] oy;
	} char_item_t;

	typedef struct {
		logic [ADDR_W-1:0]  address;
		logic [MASK_W-1:0]  mask;
		logic [COLOR_W-1:0] color;
		logic               last;
	} glyph_row_t;

	// pinned rows carry a hand-worked address and mask for the first glyph row
	typedef struct {
		char_item_t        item;
		bit                pinned;
		logic [ADDR_W-1:0] first_addr;
		logic [MASK_W-1:0] first_mask;
	} directed_row_t;

	localparam int DIRECTED_N = 20;
	directed_row_t directed_tbl [DIRECTED_N] = '{
		'{'{8'd33,  1'b1, 12'd0,    12'd0},    1'b1, 24'd0,       24'h0000F0},
		'{'{8'd127, 1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd32,  1'b0, 12'hFFF,  12'hFFF},  1'b0, 24'd0,       24'd0},
		'{'{8'd126, 1'b0, 12'd0,    12'd0},    1'b1, 24'd48,      24'h000000},
		'{'{8'd0,   1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd255, 1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd128, 1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd95,  1'b0, 12'd0,    12'd0},    1'b1, 24'd112,     24'h000000},
		'{'{8'd96,  1'b0, 12'd0,    12'd0},    1'b1, 24'd128,     24'h00000F},
		'{'{8'd35,  1'b1, 12'd10,   12'd2},    1'b1, 24'd2058,    24'h000F0F},
		'{'{8'd72,  1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd87,  1'b1, 12'hFFF,  12'hFFF},  1'b1, 24'h400BFF,  24'h000F0F},
		'{'{8'd65,  1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd48,  1'b1, 12'd4094, 12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd31,  1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'h55,  1'b1, 12'hAAA,  12'h555},  1'b0, 24'd0,       24'd0},
		'{'{8'h2A,  1'b1, 12'h555,  12'hAAA},  1'b0, 24'd0,       24'd0},
		'{'{8'd64,  1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0},
		'{'{8'd34,  1'b1, 12'd0,    12'd4095}, 1'b0, 24'd0,       24'd0},
		'{'{8'd109, 1'b0, 12'd0,    12'd0},    1'b0, 24'd0,       24'd0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sgrg_in_if  in_ch ();
	sgrg_row_if out_ch ();

	scaled_glyph_row_generator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_ch        (in_ch),
		.out_ch       (out_ch)
	);

	// predictor copy of registers and pen
	logic [SCALE_CFG_W-1:0] cfg_scale;
	logic [COLOR_W-1:0]     cfg_ink;
	logic [FW_W-1:0]        cfg_width;
	logic [ORIGIN_W-1:0]    pen_col;
	logic [ORIGIN_W-1:0]    pen_row;

	glyph_row_t rows_due[$];
	int         mismatches;
	bit         no_gaps;
	bit         park_rows;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Rows of one character, with the pen moved on afterwards
	function automatic void draw_glyph(input char_item_t it, ref glyph_row_t rows[$]);
		int                  sc;
		int                  nx;
		logic [14:0]         dots;
		logic [2:0]          trio;
		logic [47:0]         addr;
		glyph_row_t          g;
		sc = (cfg_scale == 0) ? 1 : (cfg_scale > MAX_SCALE_DEF) ? MAX_SCALE_DEF : int'(cfg_scale);
		if (it.start) begin
			pen_col = it.ox;
			pen_row = it.oy;
		end
		if (it.code >= FIRST_PRINT && it.code <= LAST_PRINT) begin
			dots = GLYPH_ROM[it.code - TABLE_BASE][14:0];
			for (int r = 0; r < GLYPH_ROWS * sc; r++) begin
				trio = 3'(dots >> ((r / sc) * GLYPH_COLS));
				g.mask = '0;
				for (int dx = 0; dx < GLYPH_COLS; dx++) begin
					if (trio[dx]) begin
						for (int j = 0; j < sc; j++) g.mask[dx * sc + j] = 1'b1;
					end
				end
				addr = (48'(pen_row) + 48'(r)) * 48'(cfg_width) + 48'(pen_col);
				g.address = addr[ADDR_W-1:0];
				g.color = cfg_ink;
				g.last = (r == GLYPH_ROWS * sc - 1);
				rows.push_back(g);
			end
		end
		nx = int'(pen_col) + GLYPH_ADVANCE * sc;
		pen_col = (nx > COORD_MAX) ? ORIGIN_W'(COORD_MAX) : ORIGIN_W'(nx);
	endfunction

	function automatic char_item_t random_char();
		char_item_t c;
		int         k;
		k = $urandom_range(99);
		if (k < 75) c.code = CODE_W'($urandom_range(126, 33));
		else if (k < 85) c.code = CODE_W'($urandom_range(32, 0));
		else c.code = CODE_W'($urandom_range(255, 127));
		// roughly one string start in seven characters
		c.start = ($urandom_range(99) < 15);
		c.ox = ORIGIN_W'($urandom);
		c.oy = ORIGIN_W'($urandom);
		if ($urandom_range(9) == 0) c.ox = ($urandom_range(1)) ? '1 : '0;
		if ($urandom_range(9) == 0) c.oy = ($urandom_range(1)) ? '1 : '0;
		return c;
	endfunction

	// Offer one item; valid stays high on return so back-to-back items need no toggle
	task automatic send_char(input char_item_t it, input bit pinned,
			input logic [ADDR_W-1:0] first_addr, input logic [MASK_W-1:0] first_mask);
		glyph_row_t rows[$];
		if (!no_gaps && $urandom_range(99) < 9) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.char_code    <= it.code;
		in_ch.start_string <= it.start;
		in_ch.origin_x     <= it.ox;
		in_ch.origin_y     <= it.oy;
		do @(posedge clk); while (!in_ch.ready);
		draw_glyph(it, rows);
		if (pinned && rows.size() > 0) begin
			rows[0].address = first_addr;
			rows[0].mask = first_mask;
		end
		foreach (rows[i]) rows_due.push_back(rows[i]);
	endtask

	task automatic random_burst(input int n);
		repeat (n) send_char(random_char(), 1'b0, '0, '0);
	endtask

	// Block is idle once all rows are in and the pen advance has had time to finish
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] scale_data,
			input logic [CFG_DATA_W-1:0] ink_data, input logic [CFG_DATA_W-1:0] width_data);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_PIXEL_SCALE;
		cfg_data     <= scale_data;
		@(posedge clk);
		cfg_index <= REG_INK_COLOR;
		cfg_data  <= ink_data;
		@(posedge clk);
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= width_data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cfg_scale = scale_data[SCALE_CFG_W-1:0];
		cfg_ink   = ink_data[COLOR_W-1:0];
		cfg_width = width_data[FW_W-1:0];
	endtask

	// Row receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (park_rows) begin
				park_rows = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= no_gaps || ($urandom_range(99) >= 9);
			end
		end
	end

	always @(posedge clk) begin : row_check
		glyph_row_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row, address %h mask %h", $time,
					out_ch.row_address, out_ch.row_mask);
				mismatches++;
			end else begin
				want = rows_due.pop_front();
				if (out_ch.row_address !== want.address) begin
					$display("%0t: row_address expected %h actual %h", $time,
						want.address, out_ch.row_address);
					mismatches++;
				end
				if (out_ch.row_mask !== want.mask) begin
					$display("%0t: row_mask expected %h actual %h", $time,
						want.mask, out_ch.row_mask);
					mismatches++;
				end
				if (out_ch.row_color !== want.color) begin
					$display("%0t: row_color expected %h actual %h", $time,
						want.color, out_ch.row_color);
					mismatches++;
				end
				if (out_ch.last_row !== want.last) begin
					$display("%0t: last_row expected %b actual %b", $time,
						want.last, out_ch.last_row);
					mismatches++;
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		no_gaps    = 1'b0;
		park_rows  = 1'b0;
		cfg_scale  = SCALE_RESET;
		cfg_ink    = COLOR_RESET;
		cfg_width  = FW_RESET;
		pen_col    = '0;
		pen_row    = '0;
		arst_n             <= 1'b0;
		cfg_write_en       <= 1'b0;
		cfg_index          <= REG_PIXEL_SCALE;
		cfg_data           <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.char_code    <= '0;
		in_ch.start_string <= 1'b0;
		in_ch.origin_x     <= '0;
		in_ch.origin_y     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: scale 4, white ink, 1024-pixel lines
		foreach (directed_tbl[i]) begin
			send_char(directed_tbl[i].item, directed_tbl[i].pinned,
				directed_tbl[i].first_addr, directed_tbl[i].first_mask);
		end

		wait_drained();
		set_config(24'd1, 24'h000000, 24'd1);
		random_burst(BURST_ITEMS);

		wait_drained();
		no_gaps = 1'b1;
		set_config(24'd8, 24'hFFFFFF, 24'd4096);
		random_burst(BURST_ITEMS);
		no_gaps = 1'b0;

		// wide lines push addresses past 2^24; rows get parked to back up the input
		wait_drained();
		set_config(24'd0, 24'h5A5A5A, 24'd8191);
		park_rows = 1'b1;
		random_burst(BURST_ITEMS);

		wait_drained();
		set_config(24'hFFFFFF, 24'hA5A5A5, 24'd0);
		random_burst(BURST_ITEMS);

		repeat (3) begin
			wait_drained();
			set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			random_burst(BURST_ITEMS);
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
